// ===== rtl/block_nesting_completion_tracker_top_assert.svh =====
// assertion macros for the nesting tracker top level
`ifndef BLOCK_NESTING_COMPLETION_TRACKER_TOP_ASSERT_SVH
`define BLOCK_NESTING_COMPLETION_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BNCT_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bnct check failed");

// next-cycle implication, quiet during reset
`define BNCT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bnct next-cycle check failed");

`endif

// ===== rtl/bnct_pkg.sv =====
`default_nettype none
package bnct_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int BANK_DEPTH  = (STACK_DEPTH + 1) / 2;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int KIND_W      = 4;
  localparam int DEPTH_OUT_W = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_W-1:0] TK_OTHER    = 4'd0;
  localparam logic [KIND_W-1:0] TK_WHILE    = 4'd1;
  localparam logic [KIND_W-1:0] TK_DO       = 4'd2;
  localparam logic [KIND_W-1:0] TK_CLASS    = 4'd3;
  localparam logic [KIND_W-1:0] TK_IF       = 4'd4;
  localparam logic [KIND_W-1:0] TK_FUNCTION = 4'd5;
  localparam logic [KIND_W-1:0] TK_END      = 4'd6;
  localparam logic [KIND_W-1:0] TK_LBRACE   = 4'd7;
  localparam logic [KIND_W-1:0] TK_RBRACE   = 4'd8;
  localparam logic [KIND_W-1:0] TK_LBRACKET = 4'd9;
  localparam logic [KIND_W-1:0] TK_RBRACKET = 4'd10;
  localparam logic [KIND_W-1:0] TK_LPAREN   = 4'd11;
  localparam logic [KIND_W-1:0] TK_RPAREN   = 4'd12;

  // classified item handed from front to back
  typedef struct packed {
    logic              clear;
    logic [KIND_W-1:0] kind;
    logic [1:0]        push_n;
    logic [KIND_W-1:0] code0;
    logic [KIND_W-1:0] code1;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/bnct_front.sv =====
`default_nettype none
module bnct_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         in_action,
  input  wire  [bnct_pkg::KIND_W-1:0] in_token_kind,
  input  wire                         q_full,
  output logic                        q_push,
  output bnct_pkg::op_t               q_op
);
  import bnct_pkg::*;

  logic op_vld_r, op_vld_nxt;
  op_t  op_r, op_nxt;
  logic take;

  always_comb begin
    op_nxt        = '0;
    op_nxt.clear  = in_action;
    op_nxt.kind   = in_token_kind;
    op_nxt.push_n = 2'd0;
    op_nxt.code0  = TK_OTHER;
    op_nxt.code1  = TK_OTHER;
    unique case (in_token_kind)
      TK_WHILE: begin
        op_nxt.push_n = 2'd2;
        op_nxt.code0  = TK_END;
        op_nxt.code1  = TK_DO;
      end
      TK_CLASS, TK_IF, TK_FUNCTION: begin
        op_nxt.push_n = 2'd1;
        op_nxt.code0  = TK_END;
      end
      TK_DO: begin
        op_nxt.push_n = 2'd1;
        op_nxt.code0  = TK_WHILE;
      end
      TK_LBRACE: begin
        op_nxt.push_n = 2'd1;
        op_nxt.code0  = TK_RBRACE;
      end
      TK_LBRACKET: begin
        op_nxt.push_n = 2'd1;
        op_nxt.code0  = TK_RBRACKET;
      end
      TK_LPAREN: begin
        op_nxt.push_n = 2'd1;
        op_nxt.code0  = TK_RPAREN;
      end
      default: begin
        op_nxt.push_n = 2'd0;
      end
    endcase
  end

  assign in_stall = op_vld_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = op_vld_r && !q_full;
  assign q_op     = op_r;

  always_comb begin
    if (take) begin
      op_vld_nxt = 1'b1;
    end else if (!q_full) begin
      op_vld_nxt = 1'b0;
    end else begin
      op_vld_nxt = op_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else begin
      op_vld_r <= op_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= op_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bnct_queue.sv =====
`default_nettype none
module bnct_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire bnct_pkg::op_t push_op,
  output logic               full,
  input  wire                pop,
  output logic               head_vld,
  output bnct_pkg::op_t      head_op
);
  import bnct_pkg::*;

  op_t                  slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_op  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bnct_back.sv =====
`default_nettype none
module bnct_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_vld,
  input  wire bnct_pkg::op_t               q_op,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_balanced,
  output logic [bnct_pkg::DEPTH_OUT_W-1:0] out_nesting_depth,
  output logic                             out_overflowed,
  output logic                             out_error_seen
);
  import bnct_pkg::*;

  // entries split by parity so a while can push two closers in the same cycle
  logic [KIND_W-1:0]  mem0 [BANK_DEPTH];
  logic [KIND_W-1:0]  mem1 [BANK_DEPTH];

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_vld_r;
  logic               bal_r, err_r, ovf_out_r;
  logic [DEPTH_OUT_W-1:0] depth_r;

  logic [KIND_W-1:0]  rd0_r, rd1_r, fwd0_r, fwd1_r;
  logic               byp0_r, byp1_r, top_sel_r;
  logic [KIND_W-1:0]  top;

  logic               take, match;
  logic               room1, room2;
  logic               wr0, wr1;
  logic [COUNT_W-1:0] e0, e1, rd_idx;
  logic [BANK_AW-1:0] ra;
  logic               we0, we1;
  logic [BANK_AW-1:0] wa0, wa1;
  logic [KIND_W-1:0]  wd0, wd1;

  assign take  = q_vld && (!out_vld_r || !out_stall);
  assign q_pop = take;

  assign top   = top_sel_r ? (byp1_r ? fwd1_r : rd1_r) : (byp0_r ? fwd0_r : rd0_r);
  assign match = !q_op.clear && (count_r != '0) && (top == q_op.kind);

  assign room1 = (count_r < COUNT_W'(STACK_DEPTH));
  assign room2 = (count_r < COUNT_W'(STACK_DEPTH - 1));
  assign e0    = count_r;
  assign e1    = count_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    wr0       = 1'b0;
    wr1       = 1'b0;
    if (take) begin
      if (q_op.clear) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else if (match) begin
        count_nxt = count_r - 1'b1;
      end else if (q_op.push_n == 2'd2) begin
        if (room2) begin
          wr0       = 1'b1;
          wr1       = 1'b1;
          count_nxt = count_r + 2'd2;
        end else if (room1) begin
          // end fits, do is dropped
          wr0       = 1'b1;
          count_nxt = count_r + 1'b1;
          ovf_nxt   = 1'b1;
        end else begin
          ovf_nxt   = 1'b1;
        end
      end else if (q_op.push_n == 2'd1) begin
        if (room1) begin
          wr0       = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          ovf_nxt   = 1'b1;
        end
      end
    end
  end

  // route the two pushed entries to their banks
  always_comb begin
    if (!e0[0]) begin
      we0 = wr0;  wa0 = BANK_AW'(e0 >> 1);  wd0 = q_op.code0;
      we1 = wr1;  wa1 = BANK_AW'(e1 >> 1);  wd1 = q_op.code1;
    end else begin
      we1 = wr0;  wa1 = BANK_AW'(e0 >> 1);  wd1 = q_op.code0;
      we0 = wr1;  wa0 = BANK_AW'(e1 >> 1);  wd0 = q_op.code1;
    end
  end

  // fetch the next top of stack
  assign rd_idx = count_nxt - 1'b1;
  assign ra     = (count_nxt == '0) ? '0 : BANK_AW'(rd_idx >> 1);

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    rd0_r  <= mem0[ra];
    byp0_r <= we0 && (wa0 == ra);
    fwd0_r <= wd0;
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    rd1_r  <= mem1[ra];
    byp1_r <= we1 && (wa1 == ra);
    fwd1_r <= wd1;
  end

  always_ff @(posedge clk) begin
    top_sel_r <= rd_idx[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (take) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bal_r     <= (count_nxt == '0);
      depth_r   <= DEPTH_OUT_W'(count_nxt);
      ovf_out_r <= ovf_nxt;
      err_r     <= q_op.clear;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_balanced      = bal_r;
  assign out_nesting_depth = depth_r;
  assign out_overflowed    = ovf_out_r;
  assign out_error_seen    = err_r;

endmodule
`default_nettype wire

// ===== rtl/block_nesting_completion_tracker_top.sv =====
// Nesting tracker: keeps a stack of expected closing tokens and returns one
// status result (balanced, depth, sticky overflow, error echo) per token.
// Throughput is one token per clock while no stall holds the flow; an input
// transfer loads the front register, then passes through the queue and the
// back output register to the result. The rate is
// set by the back stage's top-of-stack loop:
// the stack sits in two parity banks with a registered read of the next
// top, forwarded on same-cycle writes. The four-entry queue between front
// and back absorbs output stalls. Stack entries need no clearing after reset.
`default_nettype none
`include "block_nesting_completion_tracker_top_assert.svh"
module block_nesting_completion_tracker_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_action,
  input  wire  [bnct_pkg::KIND_W-1:0]      in_token_kind,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_balanced,
  output logic [bnct_pkg::DEPTH_OUT_W-1:0] out_nesting_depth,
  output logic                             out_overflowed,
  output logic                             out_error_seen
);
  import bnct_pkg::*;

  logic q_full, q_push, q_pop, q_vld;
  op_t  fe_op, q_head;

  bnct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_token_kind (in_token_kind),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (fe_op)
  );

  bnct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_op  (fe_op),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (q_vld),
    .head_op  (q_head)
  );

  bnct_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_vld             (q_vld),
    .q_op              (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_balanced      (out_balanced),
    .out_nesting_depth (out_nesting_depth),
    .out_overflowed    (out_overflowed),
    .out_error_seen    (out_error_seen)
  );

  `BNCT_CHECK(a_err_clears, out_valid && out_error_seen, out_balanced && !out_overflowed)
  `BNCT_CHECK(a_bal_depth, out_valid && out_balanced, out_nesting_depth == '0)
  `BNCT_CHECK_NEXT(a_clear_result, q_pop && q_head.clear, out_valid && out_error_seen)

endmodule
`default_nettype wire
